// ===== hdl/dptm_pkg.sv =====
// ----------------------------------------------------------------------------
// dptm_pkg
// Shared constants, types and pad tables of the drum pad trigger unit.
// ----------------------------------------------------------------------------
package dptm_pkg;

	localparam int PAD_COUNT   = 11;
	localparam int COUNT_WIDTH = 8;
	localparam int TABLE_LEN   = 11;
	localparam int QUEUE_DEPTH = 4;

	localparam int PAD_LIVE = (PAD_COUNT < TABLE_LEN) ? PAD_COUNT : TABLE_LEN;
	localparam int PAD_W    = (PAD_LIVE > 1) ? $clog2(PAD_LIVE) : 1;
	localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

	localparam int PAD_BITS    = 4;
	localparam int SAMPLE_BITS = 10;
	localparam int NOTE_BITS   = 7;
	localparam int VEL_BITS    = 7;
	localparam int CHAN_BITS   = 4;
	localparam int STATUS_BITS = 8;
	localparam int HOLD_BITS   = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [STATUS_BITS-1:0] NOTE_ON  = 8'd144;
	localparam logic [STATUS_BITS-1:0] NOTE_OFF = 8'd128;
	localparam logic [VEL_BITS-1:0]    FULL_VEL = 7'd127;

	localparam logic                 VEL_EN_RST   = 1'b1;
	localparam logic [CHAN_BITS-1:0] CHANNEL_RST  = 4'd0;
	localparam logic [NOTE_BITS-1:0] PEDAL_RST    = 7'd56;
	localparam logic [NOTE_BITS-1:0] LINKED_RST   = 7'd49;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VEL_EN  = 2'd0,
		CFG_CHANNEL = 2'd1,
		CFG_PEDAL   = 2'd2,
		CFG_LINKED  = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		CMD_OFF = 1'b0,
		CMD_ON  = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic                    pair;
		logic [NOTE_BITS-1:0]    note;
		logic [VEL_BITS-1:0]     vel;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [NOTE_BITS-1:0] pad_note(input logic [PAD_BITS-1:0] idx);
		logic [NOTE_BITS-1:0] r;
		case (idx)
			4'd0:    r = 7'd49;
			4'd1:    r = 7'd38;
			4'd2:    r = 7'd71;
			4'd3:    r = 7'd69;
			4'd4:    r = 7'd60;
			4'd5:    r = 7'd36;
			4'd6:    r = 7'd67;
			4'd7:    r = 7'd65;
			4'd8:    r = 7'd77;
			4'd9:    r = 7'd79;
			4'd10:   r = 7'd81;
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pad_thresh(input logic [PAD_BITS-1:0] idx);
		logic [SAMPLE_BITS-1:0] r;
		case (idx)
			4'd0:    r = 10'd600;
			4'd1:    r = 10'd450;
			4'd5:    r = 10'd600;
			4'd9:    r = 10'd600;
			4'd10:   r = 10'd600;
			default: r = 10'd300;
		endcase
		return r;
	endfunction

	function automatic logic [HOLD_BITS-1:0] pad_hold(input logic [PAD_BITS-1:0] idx);
		logic [HOLD_BITS-1:0] r;
		case (idx)
			4'd0:    r = 5'd10;
			4'd1:    r = 5'd20;
			default: r = 5'd30;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/dptm_if.sv =====
// ----------------------------------------------------------------------------
// dptm_if
// Valid/ready channels for sensor items and midi message items.
// ----------------------------------------------------------------------------
interface dptm_in_if;
	logic                                valid;
	logic                                ready;
	logic [dptm_pkg::PAD_BITS-1:0]       pad;
	logic [dptm_pkg::SAMPLE_BITS-1:0]    sample;
	logic                                pedal_pressed;

	modport source (output valid, pad, sample, pedal_pressed, input ready);
	modport sink   (input valid, pad, sample, pedal_pressed, output ready);
endinterface

interface dptm_out_if;
	logic                                valid;
	logic                                ready;
	logic [dptm_pkg::STATUS_BITS-1:0]    status_byte;
	logic [dptm_pkg::NOTE_BITS-1:0]      note;
	logic [dptm_pkg::VEL_BITS-1:0]       velocity;
	logic                                last;

	modport source (output valid, status_byte, note, velocity, last, input ready);
	modport sink   (input valid, status_byte, note, velocity, last, output ready);
endinterface

// ===== hdl/dptm_front.sv =====
// ----------------------------------------------------------------------------
// dptm_front
// Accepts sensor items, tracks per-pad state and queues note commands.
// ----------------------------------------------------------------------------
module dptm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	dptm_in_if.sink                           pad_in,
	input  logic                              velocity_enable,
	input  logic [dptm_pkg::NOTE_BITS-1:0]    linked_note,
	input  dptm_pkg::q_stat_t                 q_stat,
	output logic                              push,
	output dptm_pkg::cmd_t                    push_cmd
);
	import dptm_pkg::*;

	logic                   act_q [PAD_LIVE];
	logic [COUNT_WIDTH-1:0] cnt_q [PAD_LIVE];

	logic                   fire;
	logic                   pad_ok;
	logic [PAD_W-1:0]       idx;
	logic                   cur_act;
	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [NOTE_BITS-1:0]   note;
	logic                   above;
	logic [VEL_BITS-1:0]    s_div;
	logic [VEL_BITS-1:0]    vel;
	logic                   upd;
	logic                   act_d;
	logic [COUNT_WIDTH-1:0] cnt_d;

	assign pad_in.ready = !q_stat.full;
	assign fire   = pad_in.valid && pad_in.ready;
	assign pad_ok = ({1'b0, pad_in.pad} < (PAD_BITS+1)'(PAD_LIVE));
	assign idx    = pad_in.pad[PAD_W-1:0];

	assign cur_act = act_q[idx];
	assign cur_cnt = cnt_q[idx];
	assign cnt_inc = (cur_cnt == {COUNT_WIDTH{1'b1}}) ? cur_cnt : cur_cnt + 1'b1;
	assign note    = pad_note(pad_in.pad);
	assign above   = pad_in.sample > pad_thresh(pad_in.pad);
	assign s_div   = pad_in.sample[SAMPLE_BITS-1:3];
	assign vel     = !velocity_enable ? FULL_VEL :
	                 (s_div == '0) ? '0 : s_div - 1'b1;

	always_comb begin
		upd           = 1'b0;
		act_d         = cur_act;
		cnt_d         = cur_cnt;
		push          = 1'b0;
		push_cmd.kind = CMD_ON;
		push_cmd.pair = 1'b0;
		push_cmd.note = note;
		push_cmd.vel  = vel;
		if (fire && pad_ok) begin
			if (above) begin
				upd = 1'b1;
				if (!cur_act) begin
					act_d         = 1'b1;
					cnt_d         = '0;
					push          = 1'b1;
					push_cmd.pair = !pad_in.pedal_pressed && (note == linked_note);
				end else begin
					cnt_d = cnt_inc;
				end
			end else if (cur_act) begin
				upd   = 1'b1;
				cnt_d = cnt_inc;
				if (cnt_inc > COUNT_WIDTH'(pad_hold(pad_in.pad))) begin
					act_d         = 1'b0;
					push          = 1'b1;
					push_cmd.kind = CMD_OFF;
					push_cmd.vel  = FULL_VEL;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAD_LIVE; i++) begin
				act_q[i] <= 1'b0;
				cnt_q[i] <= '0;
			end
		end else if (upd) begin
			act_q[idx] <= act_d;
			cnt_q[idx] <= cnt_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> fire && pad_ok)
		else $error("command queued without an accepted item");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && push_cmd.kind == CMD_OFF |-> !push_cmd.pair && push_cmd.vel == FULL_VEL)
		else $error("malformed note-off command");
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && pad_ok && above && !cur_act |=> act_q[$past(idx)] && cnt_q[$past(idx)] == '0)
		else $error("pad not armed after note-on");

endmodule

// ===== hdl/dptm_queue.sv =====
// ----------------------------------------------------------------------------
// dptm_queue
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module dptm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dptm_pkg::cmd_t     push_cmd,
	input  logic               pop,
	output dptm_pkg::cmd_t     head,
	output dptm_pkg::q_stat_t  q_stat
);
	import dptm_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && q_stat.full))
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && q_stat.empty))
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

// ===== hdl/dptm_back.sv =====
// ----------------------------------------------------------------------------
// dptm_back
// Turns queued note commands into midi message items.
// ----------------------------------------------------------------------------
module dptm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dptm_pkg::cmd_t                    head,
	input  dptm_pkg::q_stat_t                 q_stat,
	output logic                              pop,
	input  logic [dptm_pkg::CHAN_BITS-1:0]    midi_channel,
	input  logic [dptm_pkg::NOTE_BITS-1:0]    pedal_note,
	dptm_out_if.source                        msg_out
);
	import dptm_pkg::*;

	cmd_t cur_q;
	logic cur_v_q;
	logic second_q;
	logic fire;
	logic done;

	assign fire = msg_out.valid && msg_out.ready;
	assign done = fire && (second_q || !cur_q.pair);
	assign pop  = !q_stat.empty && (!cur_v_q || done);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_v_q  <= 1'b1;
				second_q <= 1'b0;
			end else if (done) begin
				cur_v_q  <= 1'b0;
				second_q <= 1'b0;
			end else if (fire) begin
				second_q <= 1'b1;
			end
		end
	end

	assign msg_out.valid       = cur_v_q;
	assign msg_out.status_byte = ((cur_q.kind == CMD_ON) ? NOTE_ON : NOTE_OFF)
	                             | {{(STATUS_BITS-CHAN_BITS){1'b0}}, midi_channel};
	assign msg_out.note        = second_q ? pedal_note : cur_q.note;
	assign msg_out.velocity    = cur_q.vel;
	assign msg_out.last        = second_q || !cur_q.pair;

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !msg_out.last |=> msg_out.valid && msg_out.last)
		else $error("second message of a pair missing");
	assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> cur_v_q && cur_q.pair && cur_q.kind == CMD_ON)
		else $error("second message outside a note-on pair");
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_out.valid && !msg_out.ready |=> msg_out.valid)
		else $error("message item dropped while stalled");

endmodule

// ===== hdl/drum_pad_trigger_to_midi_unit.sv =====
// ----------------------------------------------------------------------------
// drum_pad_trigger_to_midi_unit
// Drum pad sensor samples in, midi note-on and note-off messages out.
// ----------------------------------------------------------------------------
// One sensor item is taken per clock while the four-entry command queue has
// room. A pad crossing its threshold gives one note-on (two when the linked
// note is hit with the pedal up); a released pad gives one note-off. Each
// message leaves on its own clock, so a note-on pair holds the output for
// both its messages; the output side sets the sustained rate, one message
// per cycle while msg_out.ready is high. An item on an empty queue passes
// the queue entry, then cur_q in the back end. Configuration is taken on any
// clock with cfg_we high and should be written only while the unit is idle.
module drum_pad_trigger_to_midi_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	dptm_in_if.sink                           pad_in,
	dptm_out_if.source                        msg_out,
	input  logic                              cfg_we,
	input  logic [dptm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dptm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dptm_pkg::*;

	logic                 velocity_enable_q;
	logic [CHAN_BITS-1:0] midi_channel_q;
	logic [NOTE_BITS-1:0] pedal_note_q;
	logic [NOTE_BITS-1:0] linked_note_q;

	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			velocity_enable_q <= VEL_EN_RST;
			midi_channel_q    <= CHANNEL_RST;
			pedal_note_q      <= PEDAL_RST;
			linked_note_q     <= LINKED_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VEL_EN:  velocity_enable_q <= cfg_data[0];
				CFG_CHANNEL: midi_channel_q    <= cfg_data[CHAN_BITS-1:0];
				CFG_PEDAL:   pedal_note_q      <= cfg_data[NOTE_BITS-1:0];
				CFG_LINKED:  linked_note_q     <= cfg_data[NOTE_BITS-1:0];
				default:     velocity_enable_q <= velocity_enable_q;
			endcase
		end
	end

	dptm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.pad_in          (pad_in),
		.velocity_enable (velocity_enable_q),
		.linked_note     (linked_note_q),
		.q_stat          (q_stat),
		.push            (push),
		.push_cmd        (push_cmd)
	);

	dptm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	dptm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.midi_channel (midi_channel_q),
		.pedal_note   (pedal_note_q),
		.msg_out      (msg_out)
	);

endmodule

// ===== dv/tb_drum_pad_trigger_to_midi_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_drum_pad_trigger_to_midi_unit
// Self-checking bench for the drum pad trigger to midi unit. Sensor items are
// fed as pad strokes (hit, sustain, release) mixed with noise on all pads,
// under several register settings. A scoreboard predicts the midi messages
// of each accepted item and compares every message field by field, in order.
// Both channels idle at random; the message side also holds off for a long
// stretch so that the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_drum_pad_trigger_to_midi_unit;
	import dptm_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 5000;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [NOTE_BITS-1:0]   note;
		logic [VEL_BITS-1:0]    vel;
		logic                   last;
	} midi_msg_t;

	class midi_scoreboard;
		logic                   vel_scale;
		logic [CHAN_BITS-1:0]   channel;
		logic [NOTE_BITS-1:0]   pedal_note;
		logic [NOTE_BITS-1:0]   linked_note;
		logic                   active [TABLE_LEN];
		logic [COUNT_WIDTH-1:0] hold [TABLE_LEN];
		int                     note_tab [TABLE_LEN];
		int                     thr_tab [TABLE_LEN];
		int                     hold_tab [TABLE_LEN];
		midi_msg_t              expected_msgs [$];
		int                     errors;

		function new();
			vel_scale   = 1'b1;
			channel     = '0;
			pedal_note  = 7'd56;
			linked_note = 7'd49;
			note_tab    = '{49, 38, 71, 69, 60, 36, 67, 65, 77, 79, 81};
			thr_tab     = '{600, 450, 300, 300, 300, 600, 300, 300, 300, 600, 600};
			hold_tab    = '{10, 20, 30, 30, 30, 30, 30, 30, 30, 30, 30};
			for (int i = 0; i < TABLE_LEN; i++) begin
				active[i] = 1'b0;
				hold[i]   = '0;
			end
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_VEL_EN:  vel_scale   = d[0];
				CFG_CHANNEL: channel     = d[CHAN_BITS-1:0];
				CFG_PEDAL:   pedal_note  = d[NOTE_BITS-1:0];
				CFG_LINKED:  linked_note = d[NOTE_BITS-1:0];
				default: ;
			endcase
		endfunction

		function void push_msg(logic [STATUS_BITS-1:0] st, logic [NOTE_BITS-1:0] n,
				logic [VEL_BITS-1:0] v, logic l);
			midi_msg_t m;
			m.status = st + {4'd0, channel};
			m.note   = n;
			m.vel    = v;
			m.last   = l;
			expected_msgs.push_back(m);
		endfunction

		function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		function void note_sample(logic [PAD_BITS-1:0] p, logic [SAMPLE_BITS-1:0] s,
				logic ped);
			logic [NOTE_BITS-1:0] n;
			logic [VEL_BITS-1:0]  v;
			int                   q;
			if (p >= PAD_COUNT || p >= TABLE_LEN)
				return;
			n = NOTE_BITS'(note_tab[p]);
			if (int'(s) > thr_tab[p]) begin
				if (!active[p]) begin
					if (vel_scale) begin
						q = int'(s) / 8;
						q = (q == 0) ? 0 : q - 1;
						v = q[VEL_BITS-1:0];
					end else begin
						v = FULL_VEL;
					end
					active[p] = 1'b1;
					hold[p]   = '0;
					if (!ped && n == linked_note) begin
						push_msg(NOTE_ON, n, v, 1'b0);
						push_msg(NOTE_ON, pedal_note, v, 1'b1);
					end else begin
						push_msg(NOTE_ON, n, v, 1'b1);
					end
				end else begin
					hold[p] = bump(hold[p]);
				end
			end else if (active[p]) begin
				hold[p] = bump(hold[p]);
				if (int'(hold[p]) > hold_tab[p]) begin
					active[p] = 1'b0;
					push_msg(NOTE_OFF, n, FULL_VEL, 1'b1);
				end
			end
		endfunction

		function void check_msg(midi_msg_t got);
			midi_msg_t want;
			if (expected_msgs.size() == 0) begin
				$error("unexpected message: status_byte %0d note %0d velocity %0d last %0d",
					got.status, got.note, got.vel, got.last);
				errors++;
				return;
			end
			want = expected_msgs.pop_front();
			if (got.status !== want.status) begin
				$error("status_byte: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.note !== want.note) begin
				$error("note: expected %0d, got %0d", want.note, got.note);
				errors++;
			end
			if (got.vel !== want.vel) begin
				$error("velocity: expected %0d, got %0d", want.vel, got.vel);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_msgs.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dptm_in_if  pad_if ();
	dptm_out_if msg_if ();

	midi_scoreboard sb = new();

	bit calm;
	bit rx_hold_req;
	int sent;
	int stall_cycles;

	drum_pad_trigger_to_midi_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pad_in    (pad_if),
		.msg_out   (msg_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// accepted items on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (pad_if.valid && pad_if.ready)
				sb.note_sample(pad_if.pad, pad_if.sample, pad_if.pedal_pressed);
			if (msg_if.valid && msg_if.ready)
				sb.check_msg('{msg_if.status_byte, msg_if.note, msg_if.velocity, msg_if.last});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pad_if.valid && pad_if.ready) || (msg_if.valid && msg_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// message side readiness
	initial begin
		int n;
		msg_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				msg_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rx_hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				msg_if.ready <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n) @(posedge clk);
			end else begin
				msg_if.ready <= 1'b1;
				n = $urandom_range(1, 30);
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_item(input logic [PAD_BITS-1:0] p, input logic [SAMPLE_BITS-1:0] s,
			input logic ped);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			pad_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pad_if.valid         <= 1'b1;
		pad_if.pad           <= p;
		pad_if.sample        <= s;
		pad_if.pedal_pressed <= ped;
		do
			@(posedge clk);
		while (!pad_if.ready);
		sent++;
	endtask

	task automatic drain();
		pad_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
	endtask

	task automatic apply_settings(input logic ve, input logic [CHAN_BITS-1:0] ch,
			input logic [NOTE_BITS-1:0] pn, input logic [NOTE_BITS-1:0] ln);
		put_reg(CFG_VEL_EN, {6'd0, ve});
		put_reg(CFG_CHANNEL, {3'd0, ch});
		put_reg(CFG_PEDAL, pn);
		put_reg(CFG_LINKED, ln);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] hit_level(input int thr);
		return ($urandom_range(0, 7) == 0) ? SAMPLE_BITS'(thr + 1) :
			SAMPLE_BITS'($urandom_range(thr + 1, 1023));
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rest_level(input int thr);
		return ($urandom_range(0, 7) == 0) ? SAMPLE_BITS'(thr) :
			SAMPLE_BITS'($urandom_range(0, thr));
	endfunction

	task automatic send_noise();
		send_item(PAD_BITS'($urandom_range(0, 15)), SAMPLE_BITS'($urandom_range(0, 1023)),
			1'($urandom_range(0, 1)));
	endtask

	// hit, sustain, then rest samples; a few strokes are cut short
	task automatic play_stroke(input int p, input int n_high);
		int thr;
		int n_low;
		thr = sb.thr_tab[p];
		if ($urandom_range(0, 5) == 0)
			n_low = $urandom_range(0, sb.hold_tab[p]);
		else
			n_low = sb.hold_tab[p] + $urandom_range(1, 4);
		repeat (n_high)
			send_item(PAD_BITS'(p), hit_level(thr), 1'($urandom_range(0, 1)));
		repeat (n_low) begin
			if ($urandom_range(0, 7) == 0)
				send_noise();
			send_item(PAD_BITS'(p), rest_level(thr), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_strokes(input int quota);
		int goal;
		goal = sent + quota;
		while (sent < goal) begin
			if ($urandom_range(0, 4) == 0)
				send_noise();
			else
				play_stroke($urandom_range(0, 10), $urandom_range(1, 5));
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		pad_if.valid         <= 1'b0;
		pad_if.pad           <= '0;
		pad_if.sample        <= '0;
		pad_if.pedal_pressed <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at reset settings
		send_item(4'd0, 10'd1023, 1'b0);
		send_item(4'd1, 10'd451, 1'b1);
		send_item(4'd2, 10'd301, 1'b0);
		send_item(4'd15, 10'd1023, 1'b0);
		send_item(4'd11, 10'd1023, 1'b1);
		send_item(4'd3, 10'd0, 1'b0);
		send_item(4'd9, 10'd600, 1'b1);
		send_item(4'd5, 10'd601, 1'b1);
		send_item(4'd10, 10'd1023, 1'b1);
		send_item(4'd0, 10'd601, 1'b0);
		repeat (11)
			send_item(4'd0, 10'd600, 1'b1);
		send_item(4'd0, 10'd700, 1'b1);
		drain();

		// fixed velocity, top channel, linked note on another pad
		apply_settings(1'b0, 4'd15, 7'd127, 7'd38);
		rx_hold_req = 1'b1;
		run_strokes(180);
		drain();

		// no linked pad, counter saturation
		apply_settings(1'b1, 4'd0, 7'd0, 7'd0);
		run_strokes(40);
		play_stroke(2, 270);
		run_strokes(40);
		drain();

		apply_settings(1'($urandom_range(0, 1)), CHAN_BITS'($urandom_range(0, 15)),
			NOTE_BITS'($urandom_range(0, 127)),
			NOTE_BITS'(sb.note_tab[$urandom_range(0, 10)]));
		run_strokes(60);
		drain();
		run_strokes(60);
		drain();

		// last part without idling
		apply_settings(1'b1, 4'd9, 7'd0, 7'd81);
		calm = 1'b1;
		run_strokes(100);
		drain();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
